@@ src/hrrn_pkg.sv @@
// hrrn_pkg: item types, status, opcode and event codes for the hrrn scheduler
// no dependencies; imported by hrrn_process_scheduler_top
package hrrn_pkg;

    // widths fixed by the item layout
    localparam int NEED_W  = 16;
    localparam int EVENT_W = 3;
    localparam int IDX_W   = 4;

    typedef logic [1:0]         t_status;
    typedef logic [EVENT_W-1:0] t_event;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // job status codes
    localparam t_status ST_EMPTY = 2'd0;
    localparam t_status ST_WAIT  = 2'd1;
    localparam t_status ST_RUN   = 2'd2;
    localparam t_status ST_FIN   = 2'd3;

    // result event codes
    localparam t_event EV_LOADED   = 3'd0;
    localparam t_event EV_FULL     = 3'd1;
    localparam t_event EV_STARTED  = 3'd2;
    localparam t_event EV_ADVANCED = 3'd3;
    localparam t_event EV_FIN_NEXT = 3'd4;
    localparam t_event EV_IDLE     = 3'd5;

    typedef struct packed {
        logic              opcode;
        logic [NEED_W-1:0] need_time;
    } t_in_item;

    typedef struct packed {
        t_event           event_res;
        logic [IDX_W-1:0] job_index;
        logic [IDX_W-1:0] finished_index;
        logic             running;
    } t_out_item;

endpackage

@@ src/hrrn_process_scheduler_top.sv @@
// hrrn_process_scheduler_top: highest response ratio next job scheduler
// depends on hrrn_pkg (item types, status and event codes)
//
//  channel | valid       | stall        | item
//  --------+-------------+--------------+--------------------------
//  input   | i_in_valid  | o_in_stall   | i_in_item  (t_in_item)
//  output  | o_out_valid | i_out_stall  | o_out_item (t_out_item)
//
// a load goes from idle straight to done; a tick on a running job walks the table with a read
// state and a walk state per loaded entry, set by the single read port of the job memory
// a selection pass takes each loaded entry through read, check and next states; once a best job
// is held, a waiting entry also takes two products on the one shared multiplier and a compare
// reset is synchronous active low; no clearing pass, slots at or above the job count are empty
// input is stalled while an item is in work; a finished item waits in the output
// register while the next item is accepted
module hrrn_process_scheduler_top
    import hrrn_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = TIME_WIDTH;
    localparam int PW = 2 * TIME_WIDTH;

    // sequencer state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_WEND  = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PCHK  = 4'd5;
    localparam logic [3:0] S_PMUL2 = 4'd6;
    localparam logic [3:0] S_PCMP  = 4'd7;
    localparam logic [3:0] S_PNEXT = 4'd8;
    localparam logic [3:0] S_START = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        sat_inc = (v == {TW{1'b1}}) ? v : v + TW'(1);
    endfunction

    // job memory, one write and one registered read per cycle
    t_status       mem_status [TABLE_DEPTH];
    logic [TW-1:0] mem_need   [TABLE_DEPTH];
    logic [TW-1:0] mem_served [TABLE_DEPTH];
    logic [TW-1:0] mem_waited [TABLE_DEPTH];

    t_status       r_rd_status;
    logic [TW-1:0] r_rd_need;
    logic [TW-1:0] r_rd_served;
    logic [TW-1:0] r_rd_waited;

    logic          w_we;
    logic [IW-1:0] w_addr;
    t_status       w_status;
    logic [TW-1:0] w_need;
    logic [TW-1:0] w_served;
    logic [TW-1:0] w_waited;

    // control and work registers
    logic [3:0]    r_state;
    logic [CW-1:0] r_count;
    logic          r_busy;
    logic [IW-1:0] r_idx;
    logic          r_walk;
    logic          r_best_valid;
    logic [IW-1:0] r_best_idx;
    logic [TW-1:0] r_best_need;
    logic [TW-1:0] r_best_waited;
    logic          r_fin_valid;
    logic [IW-1:0] r_fin_idx;
    logic          r_started_valid;
    logic [IW-1:0] r_started_idx;
    logic          r_cur_valid;
    logic [IW-1:0] r_cur_idx;
    logic [PW-1:0] r_lhs;
    logic [PW-1:0] r_rhs;
    t_event        r_res_ev;
    logic [IW-1:0] r_res_jidx;
    logic [IW-1:0] r_res_fidx;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          in_acc;
    logic          out_free;
    logic          count_full;
    logic          idx_last;
    logic          fin_last;
    logic          run_hit;
    logic          fin_now;
    logic [TW-1:0] load_need;
    logic [TW-1:0] mul_a;
    logic [TW-1:0] mul_b;
    logic [PW-1:0] mul_p;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign count_full  = (r_count == CW'(TABLE_DEPTH));
    assign idx_last    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign fin_last    = ((CW'(r_fin_idx) + CW'(1)) == r_count);
    assign run_hit     = (r_rd_status == ST_RUN) &&
                         !(r_started_valid && (r_started_idx == r_idx));
    assign fin_now     = run_hit && (r_rd_served == r_rd_need);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // masked need, zero stored as one
    always_comb begin
        load_need = TW'(i_in_item.need_time);
        if (load_need == '0) begin
            load_need = TW'(1);
        end
    end

    // shared multiplier for the cross-multiplied ratio compare
    always_comb begin
        if (r_state == S_PMUL2) begin
            mul_a = r_best_waited;
            mul_b = r_rd_need;
        end else begin
            mul_a = r_rd_waited;
            mul_b = r_best_need;
        end
    end
    assign mul_p = {{TW{1'b0}}, mul_a} * {{TW{1'b0}}, mul_b};

    // memory write control
    always_comb begin
        w_we     = 1'b0;
        w_addr   = r_idx;
        w_status = r_rd_status;
        w_need   = r_rd_need;
        w_served = r_rd_served;
        w_waited = r_rd_waited;
        if (r_state == S_IDLE) begin
            if (in_acc && (i_in_item.opcode == OP_LOAD) && !count_full) begin
                w_we     = 1'b1;
                w_addr   = IW'(r_count);
                w_status = ST_WAIT;
                w_need   = load_need;
                w_served = '0;
                w_waited = '0;
            end
        end else if (r_state == S_WALK) begin
            if (run_hit) begin
                w_we = 1'b1;
                if (fin_now) begin
                    w_status = ST_FIN;
                end else begin
                    w_served = sat_inc(r_rd_served);
                end
            end else if (r_rd_status == ST_WAIT) begin
                w_we     = 1'b1;
                w_waited = sat_inc(r_rd_waited);
            end
        end else if (r_state == S_START) begin
            w_we     = 1'b1;
            w_addr   = r_best_idx;
            w_status = ST_RUN;
            w_need   = r_best_need;
            w_served = TW'(1);
            w_waited = r_best_waited;
        end
    end

    // job memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_status[w_addr] <= w_status;
            mem_need[w_addr]   <= w_need;
            mem_served[w_addr] <= w_served;
            mem_waited[w_addr] <= w_waited;
        end
        r_rd_status <= mem_status[r_idx];
        r_rd_need   <= mem_need[r_idx];
        r_rd_served <= mem_served[r_idx];
        r_rd_waited <= mem_waited[r_idx];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_busy          <= 1'b0;
            r_walk          <= 1'b0;
            r_best_valid    <= 1'b0;
            r_fin_valid     <= 1'b0;
            r_started_valid <= 1'b0;
            r_cur_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // output register drains unless the sequencer is loading it
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_fidx <= '0;
                        r_idx      <= '0;
                        if (i_in_item.opcode == OP_LOAD) begin
                            r_state <= S_DONE;
                            if (!count_full) begin
                                r_res_ev   <= EV_LOADED;
                                r_res_jidx <= IW'(r_count);
                                r_count    <= r_count + CW'(1);
                            end else begin
                                r_res_ev   <= EV_FULL;
                                r_res_jidx <= '0;
                            end
                        end else begin
                            r_res_jidx <= '0;
                            if (r_count == '0) begin
                                // nothing loaded yet
                                r_busy   <= 1'b0;
                                r_res_ev <= EV_IDLE;
                                r_state  <= S_DONE;
                            end else if (!r_busy) begin
                                r_walk       <= 1'b0;
                                r_best_valid <= 1'b0;
                                r_state      <= S_PRD;
                            end else begin
                                r_walk          <= 1'b1;
                                r_fin_valid     <= 1'b0;
                                r_started_valid <= 1'b0;
                                r_cur_valid     <= 1'b0;
                                r_state         <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (fin_now) begin
                        // running job done: pick the next one at this point of the walk
                        r_fin_valid  <= 1'b1;
                        r_fin_idx    <= r_idx;
                        r_best_valid <= 1'b0;
                        r_idx        <= '0;
                        r_state      <= S_PRD;
                    end else begin
                        if (run_hit) begin
                            r_cur_valid <= 1'b1;
                            r_cur_idx   <= r_idx;
                        end
                        if (idx_last) begin
                            r_state <= S_WEND;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_WEND: begin
                    r_state <= S_DONE;
                    if (r_fin_valid) begin
                        r_res_fidx <= r_fin_idx;
                        if (r_started_valid) begin
                            r_res_ev   <= EV_FIN_NEXT;
                            r_res_jidx <= r_started_idx;
                        end else begin
                            r_res_ev <= EV_IDLE;
                        end
                    end else if (r_cur_valid) begin
                        r_res_ev   <= EV_ADVANCED;
                        r_res_jidx <= r_cur_idx;
                    end else begin
                        // busy with no running job left
                        r_busy   <= 1'b0;
                        r_res_ev <= EV_IDLE;
                    end
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (r_rd_status == ST_WAIT) begin
                        if (!r_best_valid) begin
                            r_best_valid  <= 1'b1;
                            r_best_idx    <= r_idx;
                            r_best_need   <= r_rd_need;
                            r_best_waited <= r_rd_waited;
                            r_state       <= S_PNEXT;
                        end else begin
                            r_lhs   <= mul_p;
                            r_state <= S_PMUL2;
                        end
                    end else begin
                        r_state <= S_PNEXT;
                    end
                end
                S_PMUL2: begin
                    r_rhs   <= mul_p;
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    // strictly higher ratio wins, ties keep the lower slot
                    if (r_lhs > r_rhs) begin
                        r_best_idx    <= r_idx;
                        r_best_need   <= r_rd_need;
                        r_best_waited <= r_rd_waited;
                    end
                    r_state <= S_PNEXT;
                end
                S_PNEXT: begin
                    if (!idx_last) begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_PRD;
                    end else if (r_best_valid) begin
                        r_state <= S_START;
                    end else if (r_walk) begin
                        // nothing waits: resume the walk after the finished slot
                        r_busy <= 1'b0;
                        if (fin_last) begin
                            r_state <= S_WEND;
                        end else begin
                            r_idx   <= r_fin_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_res_ev <= EV_IDLE;
                        r_state  <= S_DONE;
                    end
                end
                S_START: begin
                    if (r_walk) begin
                        r_started_valid <= 1'b1;
                        r_started_idx   <= r_best_idx;
                        if (fin_last) begin
                            r_state <= S_WEND;
                        end else begin
                            r_idx   <= r_fin_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_busy     <= 1'b1;
                        r_res_ev   <= EV_STARTED;
                        r_res_jidx <= r_best_idx;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid                 <= 1'b1;
                        r_out_item.event_res        <= r_res_ev;
                        r_out_item.job_index        <= IDX_W'(r_res_jidx);
                        r_out_item.finished_index   <= IDX_W'(r_res_fidx);
                        r_out_item.running          <= r_busy;
                        r_state                     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // job count stays within the table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("job count beyond table depth");

    // a start always has a chosen job below the fill count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> (r_best_valid && (CW'(r_best_idx) < r_count)))
        else $error("start without a valid best job");

    // an accepted load into a free slot grows the count by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.opcode == OP_LOAD) && !count_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("load did not take a slot");

    // a finished item is never written over while it is stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_item)))
        else $error("output item overwritten while stalled");

    // started, advanced and finished-with-next events always report a running job
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_item.event_res == EV_STARTED) ||
                         (r_out_item.event_res == EV_FIN_NEXT) ||
                         (r_out_item.event_res == EV_ADVANCED)))
        |-> r_out_item.running)
        else $error("running flag low on a start or advance");

endmodule
